FILE: src/sorted_priority_queue_top_macros.svh
// Assertion macros for the sorted priority queue.
// Define NO_ASSERTIONS to compile them out.
`ifndef SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge out of reset
`define SPQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("spq: assertion failed");

// expression must never be true out of reset
`define SPQ_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("spq: forbidden condition seen");

`else

`define SPQ_ASSERT(lbl, prop)
`define SPQ_NEVER(lbl, expr)

`endif

`endif

FILE: src/spq_pkg.sv
`default_nettype none

package spq_pkg;

  localparam int DEPTH_DEF         = 16;
  localparam int PAYLOAD_WIDTH_DEF = 32;

  localparam int OP_W     = 2;
  localparam int PRIO_W   = 16;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 64;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_PEEK   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef enum logic {
    S_IDLE,
    S_HOLD
  } state_t;

  typedef struct packed {
    logic exec;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [PRIO_W-1:0] head_priority;
    logic [DATA_W-1:0]        head_payload;
    logic [COUNT_W-1:0]       entry_count;
    logic                     is_empty;
    logic                     is_full;
  } result_t;

endpackage

`default_nettype wire

FILE: src/spq_ctrl.sv
`default_nettype none

module spq_ctrl (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  wire              out_ready,
  output spq_pkg::cmd_t    cmd
);

  spq_pkg::state_t state_r, state_nxt;
  logic            accept;

  assign accept = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      spq_pkg::S_IDLE: begin
        if (accept) state_nxt = spq_pkg::S_HOLD;
      end
      spq_pkg::S_HOLD: begin
        // a new item may replace the result in the same cycle it is taken
        if (out_ready && !accept) state_nxt = spq_pkg::S_IDLE;
      end
      default: state_nxt = spq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      spq_pkg::S_IDLE: begin
        in_ready = 1'b1;
      end
      spq_pkg::S_HOLD: begin
        in_ready  = out_ready;
        out_valid = 1'b1;
      end
      default: begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
      end
    endcase
    cmd.exec = in_valid && in_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: src/spq_datapath.sv
`default_nettype none

module spq_datapath #(
  parameter int DEPTH         = spq_pkg::DEPTH_DEF,
  parameter int PAYLOAD_WIDTH = spq_pkg::PAYLOAD_WIDTH_DEF,
  localparam int CW           = $clog2(DEPTH + 1)
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  spq_pkg::cmd_t                      cmd,
  input  wire [spq_pkg::OP_W-1:0]            operation,
  input  wire signed [spq_pkg::PRIO_W-1:0]   item_priority,
  input  wire [spq_pkg::DATA_W-1:0]          item_payload,
  output spq_pkg::result_t                   result,
  output logic [CW-1:0]                      count,
  output logic                               full
);

  logic signed [spq_pkg::PRIO_W-1:0] prio_r   [DEPTH];
  logic signed [spq_pkg::PRIO_W-1:0] prio_nxt [DEPTH];
  logic [PAYLOAD_WIDTH-1:0]          pay_r    [DEPTH];
  logic [PAYLOAD_WIDTH-1:0]          pay_nxt  [DEPTH];
  logic [CW-1:0]                     cnt_r, cnt_nxt;
  spq_pkg::result_t                  res_r, res_nxt;

  logic [DEPTH-1:0]                  keep;
  logic [PAYLOAD_WIDTH-1:0]          new_pay;
  logic [PAYLOAD_WIDTH+spq_pkg::DATA_W-1:0] in_ext;
  logic [PAYLOAD_WIDTH+spq_pkg::DATA_W-1:0] head_ext;
  logic [CW+spq_pkg::COUNT_W-1:0]    cnt_ext;

  assign in_ext   = {{PAYLOAD_WIDTH{1'b0}}, item_payload};
  assign new_pay  = in_ext[PAYLOAD_WIDTH-1:0];
  assign head_ext = {{spq_pkg::DATA_W{1'b0}}, pay_r[0]};
  assign full     = (cnt_r == CW'(DEPTH));

  // an occupied slot stays put when its priority is not below the new one
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      keep[i] = (CW'(i) < cnt_r) && (prio_r[i] >= item_priority);
    end
  end

  always_comb begin
    prio_nxt = prio_r;
    pay_nxt  = pay_r;
    cnt_nxt  = cnt_r;
    res_nxt.status        = spq_pkg::ST_OK;
    res_nxt.head_priority = '0;
    res_nxt.head_payload  = '0;
    case (operation)
      spq_pkg::OP_INSERT: begin
        if (full) begin
          res_nxt.status = spq_pkg::ST_FULL;
        end else begin
          if (!keep[0]) begin
            prio_nxt[0] = item_priority;
            pay_nxt[0]  = new_pay;
          end
          for (int i = 1; i < DEPTH; i++) begin
            if (!keep[i]) begin
              prio_nxt[i] = keep[i-1] ? item_priority : prio_r[i-1];
              pay_nxt[i]  = keep[i-1] ? new_pay : pay_r[i-1];
            end
          end
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      spq_pkg::OP_REMOVE, spq_pkg::OP_PEEK: begin
        if (cnt_r == '0) begin
          res_nxt.status = spq_pkg::ST_EMPTY;
        end else begin
          res_nxt.head_priority = prio_r[0];
          res_nxt.head_payload  = head_ext[spq_pkg::DATA_W-1:0];
          if (operation == spq_pkg::OP_REMOVE) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
              prio_nxt[i] = prio_r[i+1];
              pay_nxt[i]  = pay_r[i+1];
            end
            cnt_nxt = cnt_r - 1'b1;
          end
        end
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
    cnt_ext = {{spq_pkg::COUNT_W{1'b0}}, cnt_nxt};
    res_nxt.entry_count = cnt_ext[spq_pkg::COUNT_W-1:0];
    res_nxt.is_empty    = (cnt_nxt == '0);
    res_nxt.is_full     = (cnt_nxt == CW'(DEPTH));
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      prio_r <= prio_nxt;
      pay_r  <= pay_nxt;
      res_r  <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.exec) begin
      cnt_r <= cnt_nxt;
    end
  end

  assign result = res_r;
  assign count  = cnt_r;

endmodule

`default_nettype wire

FILE: src/sorted_priority_queue_top.sv
// Sorted priority queue: up to DEPTH entries of signed priority and payload,
// kept highest first, ties in arrival order.
// Input channel (in_*): one item per operation - insert, remove head, peek head.
// Result channel (out_*): exactly one result item per input item, in order,
// carrying status, head entry (zero unless removed or peeked), count and flags.
// The result is registered and appears in the cycle after the item is accepted.
// Throughput: one item per cycle while results are taken; every slot compares
// against the new priority in parallel, the slot row shifting in the accept cycle.
// The result sits in an output register; a new item is accepted in the same
// cycle the waiting result is taken. While the receiver stalls, in_tready is
// low and the result holds.
// Reset (rst_n low, synchronous) empties the queue and drops any pending
// result; slot contents are not cleared and are never read while unoccupied.
`default_nettype none
`include "sorted_priority_queue_top_macros.svh"

module sorted_priority_queue_top #(
  parameter int DEPTH         = spq_pkg::DEPTH_DEF,
  parameter int PAYLOAD_WIDTH = spq_pkg::PAYLOAD_WIDTH_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  // operation[1:0], item_priority[17:2], item_payload[49:18], zero pad
  input  wire [spq_pkg::IN_TDATA_W-1:0]       in_tdata,
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  // status[1:0], head_priority[17:2], head_payload[49:18],
  // entry_count[54:50], is_empty[55], is_full[56], zero pad
  output logic [spq_pkg::OUT_TDATA_W-1:0]     out_tdata
);

  localparam int CW = $clog2(DEPTH + 1);

  spq_pkg::cmd_t    cmd;
  spq_pkg::result_t result;
  logic [CW-1:0]    count;
  logic             full;

  logic [spq_pkg::OP_W-1:0]          operation;
  logic signed [spq_pkg::PRIO_W-1:0] item_priority;
  logic [spq_pkg::DATA_W-1:0]        item_payload;

  assign operation     = in_tdata[1:0];
  assign item_priority = in_tdata[17:2];
  assign item_payload  = in_tdata[49:18];

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .cmd       (cmd)
  );

  spq_datapath #(
    .DEPTH         (DEPTH),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .operation     (operation),
    .item_priority (item_priority),
    .item_payload  (item_payload),
    .result        (result),
    .count         (count),
    .full          (full)
  );

  assign out_tdata = {7'd0, result.is_full, result.is_empty, result.entry_count,
                      result.head_payload, result.head_priority, result.status};

  `SPQ_NEVER(a_count_bound, count > CW'(DEPTH))
  `SPQ_ASSERT(a_full_reject,
    cmd.exec && operation == spq_pkg::OP_INSERT && full
    |=> out_tdata[1:0] == spq_pkg::ST_FULL && $stable(count))
  `SPQ_ASSERT(a_remove_dec,
    cmd.exec && operation == spq_pkg::OP_REMOVE && count != '0
    |=> count == $past(count) - CW'(1))
  `SPQ_ASSERT(a_exec_result, cmd.exec |=> out_tvalid)

endmodule

`default_nettype wire

FILE: verif/sorted_priority_queue_top_tb.sv
module sorted_priority_queue_top_tb;
  import spq_pkg::*;

  localparam int QDEPTH = DEPTH_DEF;
  localparam logic [OP_W-1:0] OP_NONE = 2'd3;  // unused code, must leave queue alone
  localparam logic [DATA_W-1:0] PAYLOAD_MASK =
    (PAYLOAD_WIDTH_DEF >= DATA_W) ? {DATA_W{1'b1}} : ((32'd1 << PAYLOAD_WIDTH_DEF) - 1);
  localparam int STALL_CYCLES = 200;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic out_tready = 1'b0;
  wire in_tready;
  wire out_tvalid;
  wire [OUT_TDATA_W-1:0] out_tdata;

  // queue shadow, slot 0 is the head
  bit signed [PRIO_W-1:0] q_prio [QDEPTH];
  bit [DATA_W-1:0] q_payload [QDEPTH];
  int q_count = 0;
  result_t pending [$];

  int err_count = 0;
  int n_items = 0;
  int n_results = 0;
  int n_full_rej = 0;
  int n_empty_rej = 0;
  int peak_count = 0;
  bit steady_flow = 1'b0;
  bit hold_request = 1'b0;
  int hold_left = 0;

  sorted_priority_queue_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #5 clk = ~clk;

  initial begin
    #3000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic result_t apply_op(input logic [OP_W-1:0] op,
                                       input logic signed [PRIO_W-1:0] prio,
                                       input logic [DATA_W-1:0] payload);
    result_t r;
    int i;
    r = '0;
    case (op)
      OP_INSERT: begin
        if (q_count >= QDEPTH) begin
          r.status = ST_FULL;
        end else begin
          // new entry goes behind every entry of equal or higher priority
          i = q_count;
          while (i > 0 && q_prio[i-1] < prio) begin
            q_prio[i] = q_prio[i-1];
            q_payload[i] = q_payload[i-1];
            i--;
          end
          q_prio[i] = prio;
          q_payload[i] = payload & PAYLOAD_MASK;
          q_count++;
        end
      end
      OP_REMOVE, OP_PEEK: begin
        if (q_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.head_priority = q_prio[0];
          r.head_payload = q_payload[0];
          if (op == OP_REMOVE) begin
            for (i = 0; i + 1 < q_count; i++) begin
              q_prio[i] = q_prio[i+1];
              q_payload[i] = q_payload[i+1];
            end
            q_count--;
          end
        end
      end
      default: ;
    endcase
    r.status = r.status;
    r.entry_count = q_count[COUNT_W-1:0];
    r.is_empty = (q_count == 0);
    r.is_full = (q_count == QDEPTH);
    return r;
  endfunction

  task automatic flag_error(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("ERROR at %0t: %s got %h, expected %h (result %0d)",
             $realtime, what, got, want, n_results);
    err_count++;
  endtask

  task automatic send_item(input logic [OP_W-1:0] op,
                           input logic signed [PRIO_W-1:0] prio,
                           input logic [DATA_W-1:0] payload);
    int gap;
    result_t r;
    if (!steady_flow && $urandom_range(99) < 38) begin
      gap = $urandom_range(1, 2);
      @(negedge clk);
      in_tvalid <= 1'b0;
      in_tdata <= IN_TDATA_W'({$urandom, $urandom});
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {6'b0, payload, prio, op};
    do @(posedge clk); while (!in_tready);
    r = apply_op(op, prio, payload);
    pending.push_back(r);
    n_items++;
    if (r.status == ST_FULL) n_full_rej++;
    if (r.status == ST_EMPTY) n_empty_rej++;
    if (q_count > peak_count) peak_count = q_count;
  endtask

  task automatic wait_drained();
    // drop the last item off the bus so it is not taken twice
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [PRIO_W-1:0] pick_priority();
    int roll;
    roll = $urandom_range(99);
    // narrow band makes ties common
    if (roll < 30) return PRIO_W'($urandom_range(4) - 2);
    if (roll < 40) return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
    return PRIO_W'($urandom);
  endfunction

  function automatic logic [OP_W-1:0] pick_op(input int ins_pct, input int rem_pct);
    int roll;
    roll = $urandom_range(99);
    if (roll < 3) return OP_NONE;
    if (roll < 3 + ins_pct) return OP_INSERT;
    if (roll < 3 + ins_pct + rem_pct) return OP_REMOVE;
    return OP_PEEK;
  endfunction

  // checks every result item against the oldest prediction
  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      n_results++;
      if (pending.size() == 0) begin
        flag_error("unexpected result item", out_tdata[31:0], 32'd0);
      end else begin
        want = pending.pop_front();
        if (out_tdata[1:0] !== want.status)
          flag_error("status", out_tdata[1:0], want.status);
        if (out_tdata[17:2] !== want.head_priority)
          flag_error("head_priority", out_tdata[17:2], want.head_priority);
        if (out_tdata[49:18] !== want.head_payload)
          flag_error("head_payload", out_tdata[49:18], want.head_payload);
        if (out_tdata[54:50] !== want.entry_count)
          flag_error("entry_count", out_tdata[54:50], want.entry_count);
        if (out_tdata[55] !== want.is_empty)
          flag_error("is_empty", out_tdata[55], want.is_empty);
        if (out_tdata[56] !== want.is_full)
          flag_error("is_full", out_tdata[56], want.is_full);
      end
    end
  end

  always @(negedge clk) begin : drive_ready
    if (hold_request) begin
      hold_left = STALL_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (steady_flow) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= 38);
    end
  end

  task automatic test_empty_queue();
    send_item(OP_REMOVE, 16'sh1234, 32'hA5A5A5A5);
    send_item(OP_PEEK, 16'sh7FFF, 32'hFFFFFFFF);
    send_item(OP_NONE, 16'sh8000, 32'hDEADBEEF);
  endtask

  task automatic test_order_and_ties();
    send_item(OP_INSERT, 16'sh0000, 32'h00000000);
    send_item(OP_INSERT, 16'sh7FFF, 32'hFFFFFFFF);
    send_item(OP_INSERT, 16'sh8000, 32'h00000001);
    send_item(OP_INSERT, -16'sd1, 32'h00000002);
    send_item(OP_INSERT, 16'sd1, 32'h00000003);
    // equal priorities must come out in arrival order
    send_item(OP_INSERT, 16'sd5, 32'h0000000A);
    send_item(OP_INSERT, 16'sd5, 32'h0000000B);
    send_item(OP_INSERT, 16'sd5, 32'h0000000C);
    send_item(OP_PEEK, 16'sh0000, 32'h0);
    send_item(OP_NONE, 16'sh5555, 32'h55555555);
    repeat (9) send_item(OP_REMOVE, 16'sh0000, 32'h0);
  endtask

  task automatic test_fill_and_drain();
    repeat (QDEPTH + 3) send_item(OP_INSERT, pick_priority(), $urandom);
    send_item(OP_PEEK, pick_priority(), $urandom);
    send_item(OP_NONE, pick_priority(), $urandom);
    repeat (QDEPTH + 2) send_item(OP_REMOVE, pick_priority(), $urandom);
  endtask

  task automatic test_backpressure();
    hold_request = 1'b1;
    repeat (24) send_item(pick_op(60, 25), pick_priority(), $urandom);
    wait_drained();
  endtask

  task automatic test_random_mix(input int total);
    int done;
    int seg;
    int seg_len;
    int ins;
    int rem;
    done = 0;
    seg = 0;
    while (done < total) begin
      seg_len = (seg == 3) ? 150 : $urandom_range(20, 80);
      case ($urandom_range(2))
        0: begin ins = 80; rem = 12; end
        1: begin ins = 15; rem = 65; end
        default: begin ins = 45; rem = 35; end
      endcase
      steady_flow = (seg == 3);
      repeat (seg_len) send_item(pick_op(ins, rem), pick_priority(), $urandom);
      if (seg % 6 == 5) wait_drained();
      done += seg_len;
      seg++;
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_empty_queue();
    test_order_and_ties();
    test_fill_and_drain();
    test_backpressure();
    test_random_mix(1500);
    @(negedge clk);
    in_tvalid <= 1'b0;
    wait_drained();
    repeat (4) @(posedge clk);
    $display("Ran %0d operations, checked %0d results; %0d inserts refused as full, %0d reads refused as empty.",
             n_items, n_results, n_full_rej, n_empty_rej);
    $display("Queue reached %0d of %0d entries, with random idling, a %0d-cycle output stall and a gap-free stretch.",
             peak_count, QDEPTH, STALL_CYCLES);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
